// ----- hdl/tgp_pkg.sv -----
// Shared constants, types and codes for the touchpad gesture to pointer unit.
`default_nettype none
package tgp_pkg;

	localparam int MAX_CONTACTS = 10;
	localparam int JUMP_LIMIT   = 400;
	localparam int COORD_BITS   = 16;
	localparam int WHEEL_MAX    = 400;

	localparam int IN_COORD_W = 16;
	localparam int CNT_W      = 4;
	localparam int CNT_MAX    = (1 << CNT_W) - 1;
	localparam int MDIV_W     = 8;
	localparam int SDIV_W     = 10;
	localparam int CFG_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_W      = 10;
	localparam int REM_W      = 16;
	localparam int DELTA_W    = $clog2(JUMP_LIMIT + 1) + 1;
	localparam int DIV_N      = REM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_N);
	localparam int PROD_W     = REM_W + SDIV_W;

	localparam logic [MDIV_W-1:0] MDIV_RESET = MDIV_W'(3);
	localparam logic [SDIV_W-1:0] SDIV_RESET = SDIV_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTION_DIV = 2'd0,
		REG_SCROLL_DIV = 2'd1,
		REG_SCROLL_INV = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_EVAL,
		ST_DIVA_GO,
		ST_DIVA_WAIT,
		ST_DIVB_GO,
		ST_DIVB_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic take_last;
		logic eval;
		logic div_start;
		logic div_b;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/tgp_if.sv -----
// Request channel interfaces: contact items in, pointer events out.
`default_nettype none
interface tgp_contact_if;
	import tgp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  tip_down;
	logic [IN_COORD_W-1:0] contact_x;
	logic [IN_COORD_W-1:0] contact_y;
	logic                  button_pressed;
	logic                  last_contact;

	modport source (output valid, tip_down, contact_x, contact_y, button_pressed,
		last_contact, input ready);
	modport sink (input valid, tip_down, contact_x, contact_y, button_pressed,
		last_contact, output ready);
endinterface

interface tgp_event_if;
	import tgp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] pointer_dx;
	logic signed [OUT_W-1:0] pointer_dy_up;
	logic signed [OUT_W-1:0] wheel_vertical;
	logic signed [OUT_W-1:0] wheel_horizontal;
	logic                    button_state;

	modport source (output valid, pointer_dx, pointer_dy_up, wheel_vertical,
		wheel_horizontal, button_state, input ready);
	modport sink (input valid, pointer_dx, pointer_dy_up, wheel_vertical,
		wheel_horizontal, button_state, output ready);
endinterface
`default_nettype wire

// ----- hdl/tgp_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module tgp_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [tgp_pkg::DIV_N-1:0]   dividend,
	input  wire [tgp_pkg::SDIV_W-1:0]  divisor,
	output logic                       done,
	output logic [tgp_pkg::DIV_N-1:0]  quo,
	output logic [tgp_pkg::SDIV_W-1:0] rem
);
	import tgp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [DIV_N-1:0]     quo_q;
	logic [SDIV_W-1:0]    rem_q;
	logic [SDIV_W-1:0]    dvs_q;
	logic [SDIV_W:0]      trial;
	logic                 ge;
	logic [SDIV_W:0]      diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_N-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CNT_W'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N-2:0], ge};
			rem_q <= ge ? diff[SDIV_W-1:0] : trial[SDIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ----- hdl/tgp_ctrl.sv -----
// Sequencer: item intake, delta evaluation, two divisions when needed, result commit.
`default_nettype none
module tgp_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     in_last,
	input  tgp_pkg::dp_status_t     status,
	output logic                    in_ready,
	output tgp_pkg::ctrl_cmd_t      cmd
);
	import tgp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_ACCEPT;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_last) begin
						cmd.take_last = 1'b1;
						state_d       = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.need_div ? ST_DIVA_GO : ST_FINISH;
			end
			ST_DIVA_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVA_WAIT;
			end
			ST_DIVA_WAIT: begin
				if (status.div_done) state_d = ST_DIVB_GO;
			end
			ST_DIVB_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_b     = 1'b1;
				state_d       = ST_DIVB_WAIT;
			end
			ST_DIVB_WAIT: begin
				cmd.div_b = 1'b1;
				if (status.div_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/tgp_dp.sv -----
// Datapath: report state, deltas, scroll remainders, divider and result register.
`default_nettype none
module tgp_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  tgp_pkg::ctrl_cmd_t              cmd,
	output tgp_pkg::dp_status_t             status,
	input  wire                             cfg_we,
	input  wire [tgp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [tgp_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire                             in_tip,
	input  wire [tgp_pkg::IN_COORD_W-1:0]   in_x,
	input  wire [tgp_pkg::IN_COORD_W-1:0]   in_y,
	input  wire                             in_btn,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic signed [tgp_pkg::OUT_W-1:0] out_dx,
	output logic signed [tgp_pkg::OUT_W-1:0] out_dy_up,
	output logic signed [tgp_pkg::OUT_W-1:0] out_wv,
	output logic signed [tgp_pkg::OUT_W-1:0] out_wh,
	output logic                            out_btn
);
	import tgp_pkg::*;

	typedef struct packed {
		logic signed [OUT_W-1:0] click;
		logic signed [REM_W-1:0] rem;
	} axis_t;

	function automatic logic signed [REM_W-1:0] sat_rem(input logic signed [REM_W:0] v);
		logic signed [REM_W-1:0] r;
		if (v[REM_W] != v[REM_W-1]) r = v[REM_W] ? {1'b1, {(REM_W-1){1'b0}}}
		                                           : {1'b0, {(REM_W-1){1'b1}}};
		else r = v[REM_W-1:0];
		return r;
	endfunction

	function automatic logic [REM_W-1:0] mag(input logic signed [REM_W-1:0] v);
		logic [REM_W-1:0] m;
		m = v[REM_W-1] ? REM_W'(-v) : REM_W'(v);
		return m;
	endfunction

	// clicks clamp at the wheel limit; the excess stays in the remainder
	function automatic axis_t scroll_axis(input logic [DIV_N-1:0] q,
		input logic [SDIV_W-1:0] r, input logic neg, input logic [REM_W-1:0] m,
		input logic [SDIV_W-1:0] d);
		axis_t            res;
		logic [PROD_W-1:0] big;
		logic [REM_W-1:0]  rm;
		logic [OUT_W-1:0]  c;
		big = PROD_W'(m) - PROD_W'(WHEEL_MAX) * PROD_W'(d);
		if (q > DIV_N'(WHEEL_MAX)) begin
			c  = OUT_W'(WHEEL_MAX);
			rm = big[REM_W-1:0];
		end else begin
			c  = q[OUT_W-1:0];
			rm = REM_W'(r);
		end
		res.click = neg ? -$signed(c) : $signed(c);
		res.rem   = neg ? -$signed(rm) : $signed(rm);
		return res;
	endfunction

	function automatic logic signed [OUT_W-1:0] signed_quo(input logic [DIV_N-1:0] q,
		input logic neg);
		logic signed [OUT_W-1:0] s;
		s = $signed(q[OUT_W-1:0]);
		return neg ? -s : s;
	endfunction

	// configuration
	logic [MDIV_W-1:0] mdiv_q;
	logic [SDIV_W-1:0] sdiv_q;
	logic              sinv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdiv_q <= MDIV_RESET;
			sdiv_q <= SDIV_RESET;
			sinv_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOTION_DIV: mdiv_q <= cfg_wdata[MDIV_W-1:0];
				REG_SCROLL_DIV: sdiv_q <= cfg_wdata[SDIV_W-1:0];
				REG_SCROLL_INV: sinv_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// report and history state
	logic [CNT_W-1:0]        cnt_q, slot_q, prev_cnt_q;
	logic [COORD_BITS-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                    btn_q, prev_btn_q;
	logic signed [REM_W-1:0] rem_x_q, rem_y_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [DIV_N-1:0]        qa_q, qb_q;
	logic [SDIV_W-1:0]       ra_q, rb_q;

	logic signed [COORD_BITS:0] raw_dx, raw_dy;
	logic                       jump, use_delta, scroll;
	logic signed [REM_W-1:0]    sum_x, sum_y;
	logic [DIV_N-1:0]           div_op;
	logic [SDIV_W-1:0]          div_dvs;
	logic                       div_done;
	logic [DIV_N-1:0]           div_quo;
	logic [SDIV_W-1:0]          div_rem;

	axis_t                   ax_y, ax_x;
	logic signed [OUT_W-1:0] wv, wh, mx, my;
	logic signed [REM_W-1:0] nrem_x, nrem_y;
	logic                    btn_chg, emit;

	always_comb begin
		raw_dx    = $signed({1'b0, first_x_q}) - $signed({1'b0, prev_x_q});
		raw_dy    = $signed({1'b0, first_y_q}) - $signed({1'b0, prev_y_q});
		jump      = (raw_dx > JUMP_LIMIT) || (raw_dx < -JUMP_LIMIT) ||
		            (raw_dy > JUMP_LIMIT) || (raw_dy < -JUMP_LIMIT);
		use_delta = (cnt_q != '0) && (cnt_q == prev_cnt_q) && !jump;
		scroll    = cnt_q == CNT_W'(2);
		sum_x     = sat_rem({rem_x_q[REM_W-1], rem_x_q} + (REM_W+1)'(dx_q));
		sum_y     = sat_rem({rem_y_q[REM_W-1], rem_y_q} + (REM_W+1)'(dy_q));
		if (cmd.div_b) div_op = scroll ? mag(sum_x) : mag(REM_W'(dx_q));
		else           div_op = scroll ? mag(sum_y) : mag(REM_W'(dy_q));
		div_dvs = scroll ? sdiv_q : SDIV_W'(mdiv_q);
	end

	tgp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_op),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		ax_y    = scroll_axis(qa_q, ra_q, sum_y[REM_W-1], mag(sum_y), sdiv_q);
		ax_x    = scroll_axis(qb_q, rb_q, sum_x[REM_W-1], mag(sum_x), sdiv_q);
		btn_chg = btn_q != prev_btn_q;
		wv      = '0;
		wh      = '0;
		mx      = '0;
		my      = '0;
		nrem_x  = rem_x_q;
		nrem_y  = rem_y_q;
		if (scroll) begin
			nrem_x = sum_x;
			nrem_y = sum_y;
			if (sdiv_q != '0) begin
				wv     = sinv_q ? -ax_y.click : ax_y.click;
				wh     = sinv_q ? -ax_x.click : ax_x.click;
				nrem_x = ax_x.rem;
				nrem_y = ax_y.rem;
			end
			emit = (wv != '0) || (wh != '0) || btn_chg;
		end else begin
			emit = (cnt_q == CNT_W'(1)) || btn_chg;
			if (cnt_q == CNT_W'(1)) begin
				if (mdiv_q != '0) begin
					mx = signed_quo(qb_q, dx_q[DELTA_W-1]);
					my = signed_quo(qa_q, dy_q[DELTA_W-1]);
				end else begin
					mx = OUT_W'(dx_q);
					my = OUT_W'(dy_q);
				end
			end
		end
		if (cnt_q != prev_cnt_q) begin
			nrem_x = '0;
			nrem_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			slot_q     <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_cnt_q <= '0;
			prev_btn_q <= 1'b0;
			rem_x_q    <= '0;
			rem_y_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.take) begin
				if ((slot_q < CNT_W'(MAX_CONTACTS)) && in_tip) begin
					if (cnt_q == '0) begin
						first_x_q <= in_x[COORD_BITS-1:0];
						first_y_q <= in_y[COORD_BITS-1:0];
					end
					if (cnt_q != CNT_W'(CNT_MAX)) cnt_q <= cnt_q + 1'b1;
				end
				if (slot_q != CNT_W'(CNT_MAX)) slot_q <= slot_q + 1'b1;
			end
			if (cmd.finish) begin
				rem_x_q    <= nrem_x;
				rem_y_q    <= nrem_y;
				prev_x_q   <= first_x_q;
				prev_y_q   <= first_y_q;
				prev_cnt_q <= cnt_q;
				prev_btn_q <= btn_q;
				cnt_q      <= '0;
				slot_q     <= '0;
				first_x_q  <= '0;
				first_y_q  <= '0;
			end
			if (cmd.finish && emit) out_valid <= 1'b1;
			else if (out_ready)     out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_last) btn_q <= in_btn;
		if (cmd.eval) begin
			dx_q <= use_delta ? DELTA_W'(raw_dx) : '0;
			dy_q <= use_delta ? DELTA_W'(raw_dy) : '0;
		end
		if (div_done && !cmd.div_b) begin
			qa_q <= div_quo;
			ra_q <= div_rem;
		end
		if (div_done && cmd.div_b) begin
			qb_q <= div_quo;
			rb_q <= div_rem;
		end
		if (cmd.finish && emit) begin
			out_dx    <= mx;
			out_dy_up <= -my;
			out_wv    <= wv;
			out_wh    <= wh;
			out_btn   <= btn_q;
		end
	end

	always_comb begin
		status.need_div = scroll ? (sdiv_q != '0) : ((cnt_q == CNT_W'(1)) && (mdiv_q != '0));
		status.div_done = div_done;
		status.out_free = !out_valid || out_ready;
	end
endmodule
`default_nettype wire

// ----- hdl/touchpad_gesture_to_pointer_unit.sv -----
// Top level of the touchpad gesture to pointer unit.
//
//   channel   dir  payload                                      handshake
//   contacts  in   tip_down, contact_x/y, button, last_contact  valid/ready request
//   events    out  pointer_dx/dy_up, wheel_v/h, button_state    valid/ready request
//   cfg       in   cfg_index, cfg_wdata                         cfg_we, no stall
//
// A contact that does not close a report is taken and the unit stays ready. A closing
// contact goes through evaluation and, when a division is needed, two passes (start,
// 16 steps, done) through the one shared bit-serial divider before the commit step.
// The finished event sits in an output register, so contacts
// of the next report are taken while it waits; the unit holds in its final
// step, taking no contact, only while that register is still full.
// Reset is asynchronous and clears all history.
`default_nettype none
module touchpad_gesture_to_pointer_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	tgp_contact_if.sink                   contacts,
	tgp_event_if.source                   events,
	input  wire                           cfg_we,
	input  wire [tgp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [tgp_pkg::CFG_W-1:0]      cfg_wdata
);
	import tgp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	// the sequencer owns the contact handshake
	tgp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (contacts.valid),
		.in_last  (contacts.last_contact),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	assign contacts.ready = in_ready;

	// all arithmetic and the event register live in the datapath
	tgp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_tip    (contacts.tip_down),
		.in_x      (contacts.contact_x),
		.in_y      (contacts.contact_y),
		.in_btn    (contacts.button_pressed),
		.out_valid (events.valid),
		.out_ready (events.ready),
		.out_dx    (events.pointer_dx),
		.out_dy_up (events.pointer_dy_up),
		.out_wv    (events.wheel_vertical),
		.out_wh    (events.wheel_horizontal),
		.out_btn   (events.button_state)
	);
endmodule
`default_nettype wire

// ----- hdl/tgp_checker.sv -----
// Port-level checks for the touchpad gesture to pointer unit, with its bind.
`default_nettype none
module tgp_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           in_last,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire signed [tgp_pkg::OUT_W-1:0] out_dx,
	input wire signed [tgp_pkg::OUT_W-1:0] out_dy,
	input wire signed [tgp_pkg::OUT_W-1:0] out_wv,
	input wire signed [tgp_pkg::OUT_W-1:0] out_wh,
	input wire                           out_btn
);
	import tgp_pkg::*;

	// a pending event holds still until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dx) && $stable(out_dy) &&
		$stable(out_wv) && $stable(out_wh) && $stable(out_btn))
		else $error("event changed while stalled");

	// a contact inside a report never raises an event in the next cycle
	a_no_early_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last && !out_valid |=> !out_valid)
		else $error("event without closing contact");

	// closing a report leaves no contact taken in the cycle after it
	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("contact taken while report closes");

	// an event is either motion or scroll, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_dx == '0) && (out_dy == '0)) || ((out_wv == '0) && (out_wh == '0)))
		else $error("motion and scroll in one event");

	// wheel clicks stay within the clamp
	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_wv <= WHEEL_MAX) && (out_wv >= -WHEEL_MAX) &&
		(out_wh <= WHEEL_MAX) && (out_wh >= -WHEEL_MAX))
		else $error("wheel click out of range");
endmodule

bind touchpad_gesture_to_pointer_unit tgp_checker u_tgp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (contacts.valid),
	.in_ready  (contacts.ready),
	.in_last   (contacts.last_contact),
	.out_valid (events.valid),
	.out_ready (events.ready),
	.out_dx    (events.pointer_dx),
	.out_dy    (events.pointer_dy_up),
	.out_wv    (events.wheel_vertical),
	.out_wh    (events.wheel_horizontal),
	.out_btn   (events.button_state)
);
`default_nettype wire

// ----- bench/tb_touchpad_gesture_to_pointer_unit.sv -----
// Testbench for the touchpad gesture to pointer unit: predicts events per report and checks them.
`default_nettype none
module tb_touchpad_gesture_to_pointer_unit;
	import tgp_pkg::*;

	// Longest stretch with no request moving on either channel before giving up.
	localparam int WATCHDOG_LIMIT = 5000;
	// Cycles allowed for a closing contact that yields no event to finish its divisions.
	localparam int SETTLE_CYCLES  = 60;
	// Long receiver hold-off used to fill the unit and back up the contact channel.
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic                  tip;
		logic [IN_COORD_W-1:0] x;
		logic [IN_COORD_W-1:0] y;
		logic                  btn;
		logic                  last;
	} contact_req_t;

	typedef struct {
		int dx;
		int dy_up;
		int wheel_v;
		int wheel_h;
		int btn;
	} pointer_event_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	tgp_contact_if contacts_if();
	tgp_event_if events_if();

	touchpad_gesture_to_pointer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.contacts(contacts_if),
		.events(events_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Contact requests waiting to be offered, and events the unit still owes us.
	contact_req_t   pending_contacts[$];
	pointer_event_t expected_events[$];

	// Register copies, reset values to start with.
	int mdiv_reg = 3;
	int sdiv_reg = 100;
	int scroll_inv = 0;

	// Gesture history, mirroring what the unit keeps between reports.
	int prev_x = 0;
	int prev_y = 0;
	int prev_fingers = 0;
	int prev_btn = 0;
	int rem_x = 0;
	int rem_y = 0;
	// Current report being gathered.
	int fingers_now = 0;
	int first_x = 0;
	int first_y = 0;
	int slot_cnt = 0;

	// Handshake bookkeeping, sampled on the rising edge.
	bit contact_taken;
	bit event_taken;
	int quiet_cycles;

	// Idling knobs, changed per phase; gaps and stalls are drawn from 0 up to these.
	int src_gap_max;
	int sink_stall_max;
	int src_gap_left;
	int sink_stall_left;
	bit hold_kick;
	bit hold_seen;
	int hold_left;

	// Stimulus generator state: where the leading finger currently sits.
	int gx = 32768;
	int gy = 32768;
	bit gbtn;
	int items_queued;

	// Tallies for the closing summary.
	int error_count;
	int contacts_taken;
	int reports_closed;
	int events_checked;
	int wheel_events;
	int motion_events;
	int settings_applied;

	contact_req_t next_req;

	function automatic int clip(int v, int lo, int hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Predictor: fold one accepted contact into the report and, on the closing
	// contact, work out the pointer or wheel event (if any) the unit must give.
	function automatic void track_contact(contact_req_t req);
		int dx, dy, z, w, fingers;
		int cmask;
		pointer_event_t ev;
		dx = 0;
		dy = 0;
		z = 0;
		w = 0;
		cmask = (1 << COORD_BITS) - 1;
		contacts_taken++;
		// Only the first MAX_CONTACTS slots count; later ones are ignored bar the last mark.
		if (slot_cnt < MAX_CONTACTS && req.tip) begin
			if (fingers_now == 0) begin
				first_x = int'(req.x) & cmask;
				first_y = int'(req.y) & cmask;
			end
			if (fingers_now < CNT_MAX)
				fingers_now++;
		end
		if (slot_cnt < CNT_MAX)
			slot_cnt++;
		if (req.last) begin
			reports_closed++;
			fingers = fingers_now;
			// Delta only when the finger count is held; a big jump in either axis kills both.
			if (fingers > 0 && fingers == prev_fingers) begin
				dx = first_x - prev_x;
				dy = first_y - prev_y;
				if (dx > JUMP_LIMIT || dx < -JUMP_LIMIT ||
						dy > JUMP_LIMIT || dy < -JUMP_LIMIT) begin
					dx = 0;
					dy = 0;
				end
			end
			if (fingers == 2) begin
				// Two-finger scroll: remainders saturate, clicks clamp and leave the excess behind.
				rem_y = clip(rem_y + dy, -32768, 32767);
				rem_x = clip(rem_x + dx, -32768, 32767);
				if (sdiv_reg > 0) begin
					z = clip(rem_y / sdiv_reg, -WHEEL_MAX, WHEEL_MAX);
					w = clip(rem_x / sdiv_reg, -WHEEL_MAX, WHEEL_MAX);
					rem_y -= z * sdiv_reg;
					rem_x -= w * sdiv_reg;
				end
				if (scroll_inv != 0) begin
					z = -z;
					w = -w;
				end
				if (z != 0 || w != 0 || int'(req.btn) != prev_btn) begin
					ev.dx = 0;
					ev.dy_up = 0;
					ev.wheel_v = z;
					ev.wheel_h = w;
					ev.btn = req.btn;
					expected_events.push_back(ev);
				end
			end else if (fingers == 1 || int'(req.btn) != prev_btn) begin
				// Pointer motion; a button-only event without one finger carries no motion.
				if (mdiv_reg > 0) begin
					dx /= mdiv_reg;
					dy /= mdiv_reg;
				end
				if (fingers != 1) begin
					dx = 0;
					dy = 0;
				end
				ev.dx = dx;
				ev.dy_up = -dy;
				ev.wheel_v = 0;
				ev.wheel_h = 0;
				ev.btn = req.btn;
				expected_events.push_back(ev);
			end
			if (fingers != prev_fingers) begin
				rem_x = 0;
				rem_y = 0;
			end
			prev_x = first_x;
			prev_y = first_y;
			prev_fingers = fingers & CNT_MAX;
			prev_btn = req.btn;
			fingers_now = 0;
			first_x = 0;
			first_y = 0;
			slot_cnt = 0;
		end
	endfunction

	function automatic void check_field(string field, logic [OUT_W-1:0] want,
			logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
				$signed(want), $signed(got));
			error_count++;
		end
	endfunction

	// Rising edge: record handshakes, run the predictor, check events, watch for a hang.
	always @(posedge clk) begin
		contact_taken <= arst_n && contacts_if.valid && contacts_if.ready;
		event_taken <= arst_n && events_if.valid && events_if.ready;
		if (arst_n) begin
			if (contacts_if.valid && contacts_if.ready)
				track_contact('{contacts_if.tip_down, contacts_if.contact_x,
					contacts_if.contact_y, contacts_if.button_pressed, contacts_if.last_contact});
			if (events_if.valid && events_if.ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected event: expected none, actual %0d %0d %0d %0d %0d",
						$time, events_if.pointer_dx, events_if.pointer_dy_up,
						events_if.wheel_vertical, events_if.wheel_horizontal,
						events_if.button_state);
					error_count++;
				end else begin
					pointer_event_t want;
					want = expected_events.pop_front();
					check_field("pointer_dx", OUT_W'(want.dx), events_if.pointer_dx);
					check_field("pointer_dy_up", OUT_W'(want.dy_up), events_if.pointer_dy_up);
					check_field("wheel_vertical", OUT_W'(want.wheel_v),
						events_if.wheel_vertical);
					check_field("wheel_horizontal", OUT_W'(want.wheel_h),
						events_if.wheel_horizontal);
					check_field("button_state", OUT_W'(want.btn),
						OUT_W'(events_if.button_state));
					events_checked++;
					if (want.wheel_v != 0 || want.wheel_h != 0)
						wheel_events++;
					if (want.dx != 0 || want.dy_up != 0)
						motion_events++;
				end
			end
			if ((contacts_if.valid && contacts_if.ready) || (events_if.valid && events_if.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request moved for %0d cycles, %0d events still owed", $time,
					quiet_cycles, expected_events.size());
				$display("FAILED: results differ");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Contact driver: offers queued requests on the falling edge, with a random gap between them.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!contacts_if.valid || contact_taken) begin
				if (src_gap_left > 0) begin
					src_gap_left <= src_gap_left - 1;
					contacts_if.valid <= 1'b0;
				end else if (pending_contacts.size() != 0) begin
					next_req = pending_contacts.pop_front();
					contacts_if.tip_down <= next_req.tip;
					contacts_if.contact_x <= next_req.x;
					contacts_if.contact_y <= next_req.y;
					contacts_if.button_pressed <= next_req.btn;
					contacts_if.last_contact <= next_req.last;
					contacts_if.valid <= 1'b1;
					src_gap_left <= $urandom_range(0, src_gap_max);
				end else
					contacts_if.valid <= 1'b0;
			end
		end else begin
			contacts_if.valid <= 1'b0;
			contacts_if.tip_down <= 1'b0;
			contacts_if.contact_x <= '0;
			contacts_if.contact_y <= '0;
			contacts_if.button_pressed <= 1'b0;
			contacts_if.last_contact <= 1'b0;
		end
	end

	// Event receiver: random stall after each event, plus the long hold-off when kicked.
	always @(negedge clk) begin
		if (arst_n) begin
			if (event_taken)
				sink_stall_left = $urandom_range(0, sink_stall_max);
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				events_if.ready <= 1'b0;
			end else if (sink_stall_left > 0) begin
				sink_stall_left--;
				events_if.ready <= 1'b0;
			end else
				events_if.ready <= 1'b1;
		end else
			events_if.ready <= 1'b0;
	end

	// One report: `down` touching slots spread over the first MAX_CONTACTS, the
	// leading one placed at (x, y); slots past the limit get random tips.
	function automatic void queue_report(int nslots, int down, int x, int y, bit btn);
		contact_req_t req;
		int placed, open;
		placed = 0;
		for (int i = 0; i < nslots; i++) begin
			req.x = IN_COORD_W'($urandom);
			req.y = IN_COORD_W'($urandom);
			req.btn = 1'($urandom_range(0, 1));
			req.last = (i == nslots - 1);
			if (i < MAX_CONTACTS) begin
				open = ((nslots < MAX_CONTACTS) ? nslots : MAX_CONTACTS) - i;
				req.tip = (down - placed > 0) && (down - placed >= open || $urandom_range(0, 1));
				if (req.tip && placed == 0) begin
					req.x = IN_COORD_W'(x);
					req.y = IN_COORD_W'(y);
				end
				if (req.tip)
					placed++;
			end else
				req.tip = 1'($urandom_range(0, 1));
			if (req.last)
				req.btn = btn;
			pending_contacts.push_back(req);
			items_queued++;
		end
	endfunction

	// A run of reports with a steady finger count and the leading finger wandering.
	function automatic void queue_gesture(int down, int reports, int step);
		int nslots;
		for (int r = 0; r < reports; r++) begin
			if ($urandom_range(0, 9) == 0) begin
				gx = $urandom_range(0, 65535);
				gy = $urandom_range(0, 65535);
			end else begin
				gx = clip(gx + int'($urandom_range(0, 2 * step)) - step, 0, 65535);
				gy = clip(gy + int'($urandom_range(0, 2 * step)) - step, 0, 65535);
			end
			if ($urandom_range(0, 7) == 0)
				gbtn = !gbtn;
			nslots = ((down == 0) ? 1 : down) + $urandom_range(0, 2);
			if ($urandom_range(0, 11) == 0)
				nslots = $urandom_range(nslots, 18);
			queue_report(nslots, down, gx, gy, gbtn);
		end
	endfunction

	// Mostly well-formed gestures with random content, the rest unrelated noisy reports.
	function automatic void queue_random(int target);
		int start, pick, nslots, down, step;
		start = items_queued;
		while (items_queued - start < target) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: step = 20;
				1: step = 150;
				2: step = 400;
				default: step = 600;
			endcase
			if (pick < 40)
				queue_gesture(1, $urandom_range(1, 10), step);
			else if (pick < 75)
				queue_gesture(2, $urandom_range(1, 10), step);
			else if (pick < 85)
				queue_gesture(0, $urandom_range(1, 4), step);
			else if (pick < 92) begin
				nslots = $urandom_range(1, 18);
				down = $urandom_range(0, (nslots < MAX_CONTACTS) ? nslots : MAX_CONTACTS);
				queue_report(nslots, down, $urandom_range(0, 65535), $urandom_range(0, 65535),
					1'($urandom_range(0, 1)));
			end else
				queue_gesture($urandom_range(3, MAX_CONTACTS), $urandom_range(1, 6), step);
		end
	endfunction

	// Wait until the unit has nothing in flight, then give a closing contact
	// with no event time to finish its divisions.
	task automatic settle();
		while (pending_contacts.size() != 0 || contacts_if.valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(value);
	endtask

	task automatic set_config(int mdiv, int sdiv, int inv);
		settle();
		write_reg(REG_MOTION_DIV, mdiv);
		write_reg(REG_SCROLL_DIV, sdiv);
		write_reg(REG_SCROLL_INV, inv);
		@(negedge clk);
		cfg_we <= 1'b0;
		mdiv_reg = mdiv & 8'hFF;
		sdiv_reg = sdiv & 10'h3FF;
		scroll_inv = inv & 1;
		settings_applied++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MOTION_DIV;
		cfg_wdata = '0;
		src_gap_max = 16;
		sink_stall_max = 16;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed reports under the reset register values (divide by 3, scroll per 100).
		queue_report(1, 1, 100, 100, 1'b0);        // first finger lands: event with no motion
		queue_report(1, 1, 500, 0, 1'b0);          // +400 in x, upward 100: divided motion
		queue_report(1, 1, 100, 400, 1'b0);        // -400 in x and +400 in y, right at the jump limit
		queue_report(1, 1, 65535, 65535, 1'b0);    // top of the coordinate range: jump, no motion
		queue_report(2, 2, 1000, 1000, 1'b0);      // two fingers arrive: remainders cleared, silent
		queue_report(2, 2, 1000, 1400, 1'b0);      // vertical scroll, four clicks
		queue_report(2, 2, 1350, 1400, 1'b0);      // horizontal scroll, remainder kept
		queue_report(2, 2, 1350, 1400, 1'b1);      // button press while scrolling
		queue_report(1, 0, 0, 0, 1'b0);            // no finger, button release only
		queue_report(11, 1, 32768, 32768, 1'b0);   // more slots than contacts, last one ignored
		queue_report(3, 3, 0, 65535, 1'b1);        // three fingers with a press: button event
		settle();

		// Smallest divisors.
		set_config(1, 1, 0);
		queue_random(150);

		// Largest divisors with inversion, and no idling on either side.
		set_config(255, 1023, 1);
		src_gap_max = 0;
		sink_stall_max = 0;
		queue_random(150);

		// Scroll with no divisor: a long steady drag saturates both remainders.
		set_config(0, 0, 0);
		src_gap_max = 4;
		sink_stall_max = 4;
		gx = 60000;
		gy = 1000;
		for (int r = 0; r < 90; r++) begin
			queue_report(2 + $urandom_range(0, 1), 2, gx, gy, gbtn);
			gx -= JUMP_LIMIT;
			gy += JUMP_LIMIT;
		end
		gx += JUMP_LIMIT;
		gy -= JUMP_LIMIT;
		// Same two fingers held still after switching to one unit per click: clicks clamp
		// and the excess drains over several reports.
		set_config(0, 1, 1);
		for (int r = 0; r < 12; r++)
			queue_report(2, 2, gx, gy, gbtn);

		// Receiver holds off for a long stretch while the sender keeps pushing one-finger
		// reports, so the output register fills and contacts back up.
		set_config($urandom_range(0, 255), $urandom_range(1, 1023), $urandom_range(0, 1));
		src_gap_max = 0;
		sink_stall_max = 8;
		hold_kick = !hold_kick;
		queue_gesture(1, 25, 300);
		settle();

		// Random settings with the idling patterns mixed.
		for (int p = 0; p < 3; p++) begin
			set_config($urandom_range(0, 255),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 60),
				$urandom_range(0, 1));
			src_gap_max = (p == 2) ? 0 : 16;
			sink_stall_max = (p == 1) ? 0 : 16;
			queue_random(170);
		end
		settle();

		$display("Covered %0d contacts in %0d reports over %0d register settings;",
			contacts_taken, reports_closed, settings_applied + 1);
		$display("checked %0d events, %0d with wheel clicks and %0d with pointer motion.",
			events_checked, wheel_events, motion_events);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
